FILE: sv/lreg_pkg.sv
package lreg_pkg;

    localparam int LOAD_BITS = 20;
    localparam int FRAC_BITS = 16;
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

    localparam logic [2:0] FUNC_RESET = 3'd0;
    localparam logic [2:0] FUNC_SET_LOAD = 3'd1;
    localparam logic [2:0] FUNC_FRAME = 3'd2;
    localparam logic [2:0] FUNC_MESH = 3'd3;
    localparam logic [2:0] FUNC_REQUEST = 3'd4;

    localparam logic [2:0] REG_ENABLED = 3'd0;
    localparam logic [2:0] REG_COEF_BASE = 3'd1;
    localparam logic [2:0] REG_COEF_BOOST = 3'd2;
    localparam logic [2:0] REG_HALF_LIFE = 3'd3;
    localparam logic [2:0] REG_MESH_BUDGET = 3'd4;
    localparam logic [2:0] REG_MESH_CUT = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [19:0] load;
        logic [23:0] frame_ratio;
        logic [31:0] mesh_period_us;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [19:0] recommended;
        logic        has_load;
    } t_out;

    typedef logic [15:0][30:0] t_ctab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res = '0;
        bitv = 64'd1 << 62;
        rem = v;
        for (int k = 0; k < 32; k++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Entry j holds 2^(2^-(j+1)) in Q1.30, each the floor root of the previous one.
    function automatic t_ctab build_ctab();
        t_ctab tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 0; j < 16; j++) begin
            tab[j] = c[30:0];
            c = isqrt64(c << 30);
        end
        return tab;
    endfunction

    localparam t_ctab EXP_TAB = build_ctab();

endpackage

FILE: sv/load_regulator_top.sv
// Frame sample, from acceptance to ready: restoring divide, two 16-step exp2 passes and a
// 16-step log2 squaring loop, all but the divide on one shared 32x32 multiplier.
// Request: result built in S_REQ, or at acceptance when no load is set; others act at acceptance.
// One item at a time; o_in_ready is high only while the sequencer is idle and no result waits.
// Synchronous active-low reset restores register defaults and clears the control state only.
module load_regulator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_in_ready,
    input  lreg_pkg::t_in       i_data,
    output logic                o_valid,
    input  logic                i_out_ready,
    output lreg_pkg::t_out      o_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_EXP  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_SH   = 4'd4;
    localparam logic [3:0] S_LOGI = 4'd5;
    localparam logic [3:0] S_LOGS = 4'd6;
    localparam logic [3:0] S_EMUL = 4'd7;
    localparam logic [3:0] S_REQ  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]  r_state, n_state;
    logic        r_enabled;
    logic [15:0] r_base, r_boost, r_cut;
    logic [19:0] r_hl;
    logic [31:0] r_budget;
    logic [19:0] r_load, n_load;
    logic        r_known, n_known;
    logic [19:0] r_fmin, n_fmin;
    logic        r_fmv, n_fmv;
    logic [31:0] r_mpmax, n_mpmax;
    logic [31:0] r_start, n_start;

    logic [47:0] r_dv, n_dv;
    logic [19:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic [23:0] r_ratio, n_ratio;
    logic        r_phase, n_phase;
    logic [32:0] r_n, n_n;
    logic [15:0] r_g, n_g;
    logic        r_neg, n_neg;
    logic [30:0] r_acc, n_acc;
    logic [50:0] r_t, n_t;
    logic [16:0] r_kf, n_kf;
    logic [4:0]  r_p, n_p;
    logic [17:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic        r_ovalid, n_ovalid;
    lreg_pkg::t_out r_out, n_out;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    logic        acc_in;
    logic [19:0] hl_eff;
    logic [20:0] rem2;
    logic        ge;
    logic [47:0] mag;
    logic        mag_neg;
    logic [32:0] prep_n;
    logic [15:0] prep_g;
    logic [63:0] sh_t, sh_lim, sh_res;
    logic [32:0] sh_s;
    logic [19:0] sc;
    logic [20:0] lmag;
    logic [17:0] m2;
    logic [4:0]  lead;
    logic [19:0] tgt, c1;
    logic        over, have;
    logic [19:0] rec;

    assign acc_in = i_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign hl_eff = (r_hl == 20'd0) ? 20'd1 : r_hl;
    assign rem2 = {r_rem, r_dv[47]};
    assign ge = rem2 >= {1'b0, hl_eff};
    assign m2 = prod[33:16];

    always_comb begin
        lead = 5'd0;
        for (int k = 0; k < 24; k++) begin
            if (r_ratio[k]) begin
                lead = 5'(k);
            end
        end
    end

    always_comb begin
        if (r_p >= 5'd16) begin
            lmag = {5'(r_p - 5'd16), 16'd0} + {5'd0, r_frac};
        end else begin
            lmag = {5'(5'd16 - r_p), 16'd0} - {5'd0, r_frac};
        end
    end

    always_comb begin
        case (r_state)
            S_EXP: begin
                mul_a = {1'b0, r_acc};
                mul_b = {1'b0, lreg_pkg::EXP_TAB[r_cnt[3:0]]};
            end
            S_MUL: begin
                mul_a = r_phase ? {12'd0, r_load} : {16'd0, r_boost};
                mul_b = {1'b0, r_acc};
            end
            S_LOGS: begin
                mul_a = {14'd0, r_m};
                mul_b = {14'd0, r_m};
            end
            S_EMUL: begin
                mul_a = {11'd0, lmag};
                mul_b = {15'd0, r_kf};
            end
            S_REQ: begin
                mul_a = {12'd0, r_load};
                mul_b = {16'd0, r_cut};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Exponent magnitude split: a negative exponent with a fraction borrows one.
    always_comb begin
        if (r_state == S_DIV) begin
            mag = {r_dv[46:0], ge};
            mag_neg = 1'b1;
        end else begin
            mag = {26'd0, prod[37:16]};
            mag_neg = (r_p >= 5'd16);
        end
        if (mag_neg && mag[15:0] != 16'd0) begin
            prep_n = {1'b0, mag[47:16]} + 33'd1;
            prep_g = 16'(17'h10000 - {1'b0, mag[15:0]});
        end else begin
            prep_n = {1'b0, mag[47:16]};
            prep_g = mag[15:0];
        end
    end

    always_comb begin
        sh_t = {13'd0, r_t};
        sh_lim = r_phase ? {44'd0, lreg_pkg::LOAD_MAX} : 64'd65535;
        sh_s = r_n - 33'd30;
        if (r_neg) begin
            if (r_n >= 33'd34) begin
                sh_res = '0;
            end else begin
                sh_res = sh_t >> (7'(r_n[5:0]) + 7'd30);
            end
        end else if (sh_t == 64'd0) begin
            sh_res = '0;
        end else if (r_n >= 33'd30) begin
            if (sh_s >= 33'd62) begin
                sh_res = sh_lim;
            end else if (sh_t > (sh_lim >> sh_s[5:0])) begin
                sh_res = sh_lim;
            end else begin
                sh_res = sh_t << sh_s[5:0];
            end
        end else begin
            sh_res = sh_t >> (5'd30 - r_n[4:0]);
        end
        sc = (sh_res > sh_lim) ? sh_lim[19:0] : sh_res[19:0];
        if (sc == r_load) begin
            tgt = (r_load == lreg_pkg::LOAD_MAX) ? lreg_pkg::LOAD_MAX : r_load + 20'd1;
        end else begin
            tgt = sc;
        end
    end

    always_comb begin
        c1 = (prod[35:16] == 20'd0) ? 20'd0 : prod[35:16] - 20'd1;
        over = (r_mpmax != 32'd0) && (r_mpmax >= r_budget);
        rec = r_fmin;
        have = r_fmv;
        if (over && (!have || c1 < rec)) begin
            rec = c1;
            have = 1'b1;
        end
        if (!have) begin
            rec = r_load;
        end
    end

    always_comb begin
        n_state = r_state;
        n_load = r_load;
        n_known = r_known;
        n_fmin = r_fmin;
        n_fmv = r_fmv;
        n_mpmax = r_mpmax;
        n_start = r_start;
        n_dv = r_dv;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_ratio = r_ratio;
        n_phase = r_phase;
        n_n = r_n;
        n_g = r_g;
        n_neg = r_neg;
        n_acc = r_acc;
        n_t = r_t;
        n_kf = r_kf;
        n_p = r_p;
        n_m = r_m;
        n_frac = r_frac;
        n_ovalid = r_ovalid;
        n_out = r_out;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    case (i_data.func)
                        lreg_pkg::FUNC_RESET: begin
                            n_start = i_data.now_ms;
                            n_load = '0;
                            n_known = 1'b0;
                            n_fmin = '0;
                            n_fmv = 1'b0;
                            n_mpmax = '0;
                        end
                        lreg_pkg::FUNC_SET_LOAD: begin
                            n_load = i_data.load;
                            n_known = 1'b1;
                        end
                        lreg_pkg::FUNC_FRAME: begin
                            if (r_enabled && r_known && i_data.frame_ratio != 24'd0) begin
                                n_dv = {i_data.now_ms - r_start, 16'd0};
                                n_rem = '0;
                                n_cnt = '0;
                                n_ratio = i_data.frame_ratio;
                                n_phase = 1'b0;
                                n_state = S_DIV;
                            end
                        end
                        lreg_pkg::FUNC_MESH: begin
                            if (r_enabled && i_data.mesh_period_us > r_mpmax) begin
                                n_mpmax = i_data.mesh_period_us;
                            end
                        end
                        lreg_pkg::FUNC_REQUEST: begin
                            if (r_known) begin
                                n_state = S_REQ;
                            end else begin
                                n_out = '0;
                                n_ovalid = 1'b1;
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem = ge ? 20'(rem2 - {1'b0, hl_eff}) : rem2[19:0];
                n_dv = {r_dv[46:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    n_n = prep_n;
                    n_g = prep_g;
                    n_neg = 1'b1;
                    n_acc = 31'h4000_0000;
                    n_cnt = '0;
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (r_g[4'd15 - r_cnt[3:0]]) begin
                    n_acc = prod[60:30];
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_cnt = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_t = prod[50:0];
                n_state = S_SH;
            end
            S_SH: begin
                if (!r_phase) begin
                    n_kf = {1'b0, r_base} + {1'b0, sc[15:0]};
                    n_state = S_LOGI;
                end else begin
                    if (!r_fmv || tgt < r_fmin) begin
                        n_fmin = tgt;
                        n_fmv = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LOGI: begin
                // Normalize the ratio to [1,2) in Q1.16 by truncation.
                n_p = lead;
                if (lead > 5'd16) begin
                    n_m = 18'(r_ratio >> (lead - 5'd16));
                end else begin
                    n_m = 18'(r_ratio << (5'd16 - lead));
                end
                n_frac = '0;
                n_cnt = '0;
                n_state = S_LOGS;
            end
            S_LOGS: begin
                if (m2 >= 18'h20000) begin
                    n_frac[4'd15 - r_cnt[3:0]] = 1'b1;
                    n_m = m2 >> 1;
                end else begin
                    n_m = m2;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_cnt = '0;
                    n_state = S_EMUL;
                end
            end
            S_EMUL: begin
                n_n = prep_n;
                n_g = prep_g;
                n_neg = mag_neg;
                n_acc = 31'h4000_0000;
                n_phase = 1'b1;
                n_state = S_EXP;
            end
            S_REQ: begin
                n_out.recommended = rec;
                n_out.has_load = 1'b1;
                n_ovalid = 1'b1;
                n_fmin = '0;
                n_fmv = 1'b0;
                n_mpmax = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_ovalid && i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_enabled <= 1'b1;
            r_base <= 16'd1638;
            r_boost <= 16'd14746;
            r_hl <= 20'd10000;
            r_budget <= 32'd350000;
            r_cut <= 16'd65372;
            r_load <= '0;
            r_known <= 1'b0;
            r_fmin <= '0;
            r_fmv <= 1'b0;
            r_mpmax <= '0;
            r_start <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_load <= n_load;
            r_known <= n_known;
            r_fmin <= n_fmin;
            r_fmv <= n_fmv;
            r_mpmax <= n_mpmax;
            r_start <= n_start;
            r_ovalid <= n_ovalid;
            r_cnt <= n_cnt;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lreg_pkg::REG_ENABLED:     r_enabled <= i_cfg_data[0];
                    lreg_pkg::REG_COEF_BASE:   r_base <= i_cfg_data[15:0];
                    lreg_pkg::REG_COEF_BOOST:  r_boost <= i_cfg_data[15:0];
                    lreg_pkg::REG_HALF_LIFE:   r_hl <= i_cfg_data[19:0];
                    lreg_pkg::REG_MESH_BUDGET: r_budget <= i_cfg_data;
                    lreg_pkg::REG_MESH_CUT:    r_cut <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv <= n_dv;
        r_rem <= n_rem;
        r_ratio <= n_ratio;
        r_n <= n_n;
        r_g <= n_g;
        r_neg <= n_neg;
        r_acc <= n_acc;
        r_t <= n_t;
        r_kf <= n_kf;
        r_p <= n_p;
        r_m <= n_m;
        r_frac <= n_frac;
        r_out <= n_out;
    end

endmodule

FILE: bench/load_regulator_checker.sv
`timescale 1ns / 1ps

module load_regulator_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_in_ready,
    input  lreg_pkg::t_in   i_data,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  lreg_pkg::t_out  i_out_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    output int              o_errors,
    output int              o_pending
);

    localparam logic [63:0] LIMIT = 64'hFFFFF;

    logic [0:0]  en_q;
    logic [15:0] base_q, boost_q, cut_q;
    logic [19:0] half_q;
    logic [31:0] budget_q;

    logic [19:0] cur_load;
    logic        load_set;
    logic [19:0] fmin;
    logic        fmin_ok;
    logic [31:0] mesh_max;
    logic [31:0] t_start;

    int          err_count = 0;
    int          pend_count = 0;

    lreg_pkg::t_out recs_q[$];

    assign o_errors = err_count;
    assign o_pending = pend_count;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] pow2_frac(input logic [63:0] g);
        logic [63:0] acc, c;
        acc = 64'd1 << 30;
        c = root64(64'd1 << 61);
        for (int i = 1; i <= 16; i++) begin
            if (g[16-i]) acc = (acc * c) >> 30;
            c = root64(c << 30);
        end
        return acc;
    endfunction

    function automatic logic [63:0] apply_pow2(input logic [63:0] v, input logic neg,
                                               input logic [63:0] mag,
                                               input logic [63:0] lim);
        logic [63:0] n, g, t, r, s;
        n = mag >> 16;
        g = mag & 64'hFFFF;
        if (neg) begin
            if (g != 0) begin
                n = n + 64'd1;
                g = 64'h10000 - g;
            end
            t = v * pow2_frac(g);
            if (n >= 64'd34) return '0;
            r = t >> (n + 64'd30);
            return r > lim ? lim : r;
        end
        t = v * pow2_frac(g);
        if (t == 0) return '0;
        if (n >= 64'd30) begin
            s = n - 64'd30;
            if (s >= 64'd62) return lim;
            if (t > (lim >> s)) return lim;
            return t << s;
        end
        r = t >> (64'd30 - n);
        return r > lim ? lim : r;
    endfunction

    function automatic logic [63:0] frame_goal(input logic [23:0] ratio,
                                               input logic [31:0] now);
        logic [63:0] elapsed, hl, x, k, m, frac, lmag, emag, t, ld;
        logic        neg;
        int          p;
        ld = 64'(cur_load);
        elapsed = 64'(now - t_start);
        hl = half_q != 0 ? 64'(half_q) : 64'd1;
        x = (elapsed << 16) / hl;
        k = 64'(base_q) + apply_pow2(64'(boost_q), 1'b1, x, 64'd65535);
        p = 23;
        while (p > 0 && !ratio[p]) p--;
        m = p > 16 ? (64'(ratio) >> (p - 16)) : (64'(ratio) << (16 - p));
        frac = '0;
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 16;
            if (m >= (64'd2 << 16)) begin
                frac[16-i] = 1'b1;
                m = m >> 1;
            end
        end
        if (p >= 16) begin
            lmag = (64'(p - 16) << 16) + frac;
            neg = 1'b1;
        end else begin
            lmag = (64'(16 - p) << 16) - frac;
            neg = 1'b0;
        end
        emag = (lmag * k) >> 16;
        t = apply_pow2(ld, neg, emag, LIMIT);
        if (t == ld) t = ld + 64'd1 > LIMIT ? LIMIT : ld + 64'd1;
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic apply_request(input lreg_pkg::t_in req);
        logic [63:0]    cut, rec;
        logic           have;
        lreg_pkg::t_out res;
        case (req.func)
            lreg_pkg::FUNC_RESET: begin
                t_start = req.now_ms;
                cur_load = '0;
                load_set = 1'b0;
                fmin = '0;
                fmin_ok = 1'b0;
                mesh_max = '0;
            end
            lreg_pkg::FUNC_SET_LOAD: begin
                cur_load = req.load;
                load_set = 1'b1;
            end
            lreg_pkg::FUNC_FRAME: begin
                if (en_q && load_set && req.frame_ratio != 0) begin
                    rec = frame_goal(req.frame_ratio, req.now_ms);
                    if (!fmin_ok || rec < 64'(fmin)) begin
                        fmin = rec[19:0];
                        fmin_ok = 1'b1;
                    end
                end
            end
            lreg_pkg::FUNC_MESH: begin
                if (en_q && req.mesh_period_us > mesh_max) mesh_max = req.mesh_period_us;
            end
            lreg_pkg::FUNC_REQUEST: begin
                if (!load_set) begin
                    res = '{recommended: 20'd0, has_load: 1'b0};
                end else begin
                    rec = 64'(fmin);
                    have = fmin_ok;
                    if (mesh_max != 0 && mesh_max >= budget_q) begin
                        cut = (64'(cur_load) * 64'(cut_q)) >> 16;
                        cut = cut > 0 ? cut - 64'd1 : 64'd0;
                        if (!have || cut < rec) begin
                            rec = cut;
                            have = 1'b1;
                        end
                    end
                    if (!have) rec = 64'(cur_load);
                    fmin = '0;
                    fmin_ok = 1'b0;
                    mesh_max = '0;
                    res = '{recommended: rec[19:0], has_load: 1'b1};
                end
                recs_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        lreg_pkg::t_out want;
        if (!i_rst_n) begin
            en_q = 1'b1;
            base_q = 16'd1638;
            boost_q = 16'd14746;
            half_q = 20'd10000;
            budget_q = 32'd350000;
            cut_q = 16'd65372;
            cur_load = '0;
            load_set = 1'b0;
            fmin = '0;
            fmin_ok = 1'b0;
            mesh_max = '0;
            t_start = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lreg_pkg::REG_ENABLED:     en_q = i_cfg_data[0];
                    lreg_pkg::REG_COEF_BASE:   base_q = i_cfg_data[15:0];
                    lreg_pkg::REG_COEF_BOOST:  boost_q = i_cfg_data[15:0];
                    lreg_pkg::REG_HALF_LIFE:   half_q = i_cfg_data[19:0];
                    lreg_pkg::REG_MESH_BUDGET: budget_q = i_cfg_data;
                    lreg_pkg::REG_MESH_CUT:    cut_q = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (recs_q.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = recs_q.pop_front();
                    if (i_out_data.recommended !== want.recommended)
                        report_mismatch($sformatf("recommended %0d, expected %0d",
                                                  i_out_data.recommended, want.recommended));
                    if (i_out_data.has_load !== want.has_load)
                        report_mismatch($sformatf("has_load %0b, expected %0b",
                                                  i_out_data.has_load, want.has_load));
                end
            end
            if (i_valid && i_in_ready) apply_request(i_data);
        end
        pend_count = recs_q.size();
    end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_RANDOM = 1200;
    localparam longint CYCLE_LIMIT = 2000000;

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           i_valid = 0;
    logic           o_in_ready;
    lreg_pkg::t_in  i_data = '0;
    logic           o_valid;
    logic           i_out_ready = 0;
    lreg_pkg::t_out o_data;
    logic           i_cfg_we = 0;
    logic [2:0]     i_cfg_idx = '0;
    logic [31:0]    i_cfg_data = '0;
    int             errors, pending;
    longint         cycles = 0;
    logic           calm = 0;
    logic [31:0]    clock_ms = 0;

    load_regulator_top dut (.*);

    load_regulator_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_in_ready), .i_data,
        .i_out_valid(o_valid), .i_out_ready, .i_out_data(o_data),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side stalls in bursts.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(3) == 0) begin
                n = $urandom_range(8, 1);
                i_out_ready <= 0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    end

    // Valid stays high from one request to the next unless an idle burst comes between.
    task automatic send(input lreg_pkg::t_in req);
        i_cfg_we <= 0;
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        i_data <= req;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] f, input logic [19:0] ld,
                           input logic [23:0] ratio, input logic [31:0] mp,
                           input logic [31:0] now);
        lreg_pkg::t_in req;
        req = '{func: f, load: ld, frame_ratio: ratio, mesh_period_us: mp, now_ms: now};
        send(req);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        // A frame sample may still be running with no result behind it.
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_ratio();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return 24'(32'h10000 + $urandom_range(16384) - 32'd8192);
            2: return 24'($urandom_range(255, 1));
            default: return 24'($urandom_range(32'h30000, 32'h8000));
        endcase
    endfunction

    task automatic random_item();
        logic [2:0]    f;
        lreg_pkg::t_in req;
        logic [127:0]  raw;
        int            r;
        r = $urandom_range(99);
        if (r < 3) f = lreg_pkg::FUNC_RESET;
        else if (r < 13) f = lreg_pkg::FUNC_SET_LOAD;
        else if (r < 58) f = lreg_pkg::FUNC_FRAME;
        else if (r < 75) f = lreg_pkg::FUNC_MESH;
        else if (r < 97) f = lreg_pkg::FUNC_REQUEST;
        else f = 3'($urandom_range(7, 5));
        clock_ms = clock_ms + $urandom_range(2000);
        raw = {$urandom, $urandom, $urandom, $urandom};
        req = raw[$bits(lreg_pkg::t_in)-1:0];
        req.func = f;
        if ($urandom_range(3) != 0) begin
            req.now_ms = $urandom_range(7) == 0 ? $urandom : clock_ms;
            req.frame_ratio = pick_ratio();
            req.mesh_period_us = $urandom_range(1) ? $urandom_range(700000) : $urandom;
            if ($urandom_range(1)) req.load = 20'($urandom_range(5000));
        end
        send(req);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: request before any load, then extremes.
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'h10000, '0, '0);
        send_op(lreg_pkg::FUNC_RESET, '0, '0, '0, 32'd100);
        send_op(lreg_pkg::FUNC_SET_LOAD, 20'hFFFFF, '0, '0, '0);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'h10000, '0, 32'd100);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'd1, '0, 32'd50);
        send_op(lreg_pkg::FUNC_FRAME, '0, '0, '0, 32'd50);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        send_op(lreg_pkg::FUNC_SET_LOAD, 20'd1000, '0, '0, '0);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'hFFFFFF, '0, 32'hFFFFFFFF);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'h18000, '0, 32'd20000);
        send_op(lreg_pkg::FUNC_MESH, '0, '0, 32'hFFFFFFFF, '0);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        send_op(lreg_pkg::FUNC_SET_LOAD, 20'd0, '0, '0, '0);
        send_op(lreg_pkg::FUNC_MESH, '0, '0, 32'd400000, '0);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        send_op(3'd7, 20'hFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        drain();

        set_reg(lreg_pkg::REG_ENABLED, 32'd0);
        set_reg(lreg_pkg::REG_MESH_BUDGET, 32'd0);
        set_reg(lreg_pkg::REG_HALF_LIFE, 32'd0);
        send_op(lreg_pkg::FUNC_SET_LOAD, 20'd500, '0, '0, '0);
        send_op(lreg_pkg::FUNC_FRAME, '0, 24'h20000, '0, 32'd5);
        send_op(lreg_pkg::FUNC_MESH, '0, '0, 32'd1, '0);
        send_op(lreg_pkg::FUNC_REQUEST, '0, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    set_reg(lreg_pkg::REG_ENABLED, 32'd1);
                    set_reg(lreg_pkg::REG_COEF_BASE, 32'hFFFF);
                    set_reg(lreg_pkg::REG_COEF_BOOST, 32'hFFFF);
                    set_reg(lreg_pkg::REG_HALF_LIFE, 32'd1);
                    set_reg(lreg_pkg::REG_MESH_CUT, 32'hFFFF);
                end
                1: begin
                    set_reg(lreg_pkg::REG_COEF_BASE, 32'd0);
                    set_reg(lreg_pkg::REG_COEF_BOOST, 32'd0);
                    set_reg(lreg_pkg::REG_HALF_LIFE, 32'hFFFFF);
                    set_reg(lreg_pkg::REG_MESH_BUDGET, 32'hFFFFFFFF);
                    set_reg(lreg_pkg::REG_MESH_CUT, 32'd0);
                end
                2: begin
                    set_reg(lreg_pkg::REG_HALF_LIFE, 32'd1000000);
                    set_reg(lreg_pkg::REG_COEF_BOOST, $urandom_range(65535));
                    set_reg(lreg_pkg::REG_COEF_BASE, $urandom_range(65535));
                    set_reg(lreg_pkg::REG_MESH_BUDGET, $urandom_range(700000));
                    set_reg(lreg_pkg::REG_MESH_CUT, $urandom_range(65535));
                end
                3: set_reg(lreg_pkg::REG_ENABLED, 32'd0);
                4: begin
                    set_reg(lreg_pkg::REG_ENABLED, 32'd1);
                    set_reg(lreg_pkg::REG_COEF_BASE, 32'd1638);
                    set_reg(lreg_pkg::REG_COEF_BOOST, 32'd14746);
                    set_reg(lreg_pkg::REG_HALF_LIFE, 32'd10000);
                    set_reg(lreg_pkg::REG_MESH_BUDGET, 32'd350000);
                    set_reg(lreg_pkg::REG_MESH_CUT, 32'd65372);
                end
                default: calm = 1;
            endcase
            repeat (N_RANDOM / 6) random_item();
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
